// ===== hw/rtl/tlex_pkg.sv =====
package tlex_pkg;

  localparam int unsigned ResDepth = 4;

  localparam logic [7:0] ChNl      = 8'h0A;
  localparam logic [7:0] ChPct     = 8'h25;
  localparam logic [7:0] ChLParen  = 8'h28;
  localparam logic [7:0] ChRParen  = 8'h29;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChLBrack  = 8'h5B;
  localparam logic [7:0] ChRBrack  = 8'h5D;
  localparam logic [7:0] ChUscore  = 8'h5F;
  localparam logic [7:0] ChLBrace  = 8'h7B;
  localparam logic [7:0] ChRBrace  = 8'h7D;

  typedef enum logic [3:0] {
    StStart   = 4'd0,
    StComment = 4'd1,
    StInt     = 4'd2,
    StFloat   = 4'd3,
    StString  = 4'd4,
    StToken   = 4'd5,
    StRef     = 4'd6,
    StBlkOpen = 4'd7,
    StBlkClos = 4'd8,
    StArrOpen = 4'd9,
    StArrClos = 4'd10
  } lex_state_e;

  typedef enum logic [2:0] {
    ActCopy   = 3'd0,
    ActOutput = 3'd1,
    ActUnget  = 3'd2,
    ActIgnore = 3'd3,
    ActAbort  = 3'd4
  } lex_act_e;

  typedef enum logic [3:0] {
    EvChar     = 4'd0,
    EvComment  = 4'd1,
    EvInt      = 4'd2,
    EvFloat    = 4'd3,
    EvString   = 4'd4,
    EvToken    = 4'd5,
    EvRef      = 4'd6,
    EvBlkOpen  = 4'd7,
    EvBlkClos  = 4'd8,
    EvArrOpen  = 4'd9,
    EvArrClos  = 4'd10,
    EvAbort    = 4'd11
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e    kind;
    logic [7:0]  data;
    logic        last;
  } res_t;

endpackage

// ===== hw/rtl/tlex_decode.sv =====
module tlex_decode
  import tlex_pkg::*;
(
  input  lex_state_e state_i,
  input  logic [7:0] byte_i,
  output lex_state_e next_o,
  output lex_act_e   act_o
);

  logic sp, al, dg, spc;

  assign sp  = (byte_i == 8'h20) || (byte_i >= 8'h09 && byte_i <= 8'h0D);
  assign al  = (byte_i >= 8'h61 && byte_i <= 8'h7A) || (byte_i >= 8'h41 && byte_i <= 8'h5A);
  assign dg  = (byte_i >= 8'h30 && byte_i <= 8'h39);
  assign spc = (byte_i == ChStar) || (byte_i == ChUscore);

  always_comb begin
    next_o = StStart;
    act_o  = ActAbort;
    case (state_i)
      StComment: begin
        if (byte_i == ChNl) begin
          act_o = ActOutput;
        end else begin
          next_o = StComment;
          act_o  = ActCopy;
        end
      end
      StInt: begin
        if (dg) begin
          next_o = StInt;
          act_o  = ActCopy;
        end else if (sp) begin
          act_o = ActOutput;
        end else if (byte_i == ChRBrack) begin
          act_o = ActUnget;
        end else if (byte_i == ChDot) begin
          next_o = StFloat;
          act_o  = ActCopy;
        end
      end
      StFloat: begin
        if (dg) begin
          next_o = StFloat;
          act_o  = ActCopy;
        end else if (sp) begin
          act_o = ActOutput;
        end
      end
      StString: begin
        if (byte_i == ChRParen) begin
          act_o = ActOutput;
        end else begin
          next_o = StString;
          act_o  = ActCopy;
        end
      end
      StToken: begin
        if (dg || al || spc) begin
          next_o = StToken;
          act_o  = ActCopy;
        end else if (sp) begin
          act_o = ActOutput;
        end else if (byte_i == ChLBrace) begin
          next_o = StBlkOpen;
          act_o  = ActOutput;
        end else if (byte_i == ChRBrace) begin
          next_o = StBlkClos;
          act_o  = ActOutput;
        end
      end
      StBlkOpen, StBlkClos, StArrOpen, StArrClos: begin
        act_o = ActUnget;
      end
      StRef: begin
        if (al || dg) begin
          next_o = StRef;
          act_o  = ActCopy;
        end else begin
          act_o = ActUnget;
        end
      end
      default: begin
        if (byte_i == ChPct) begin
          next_o = StComment;
          act_o  = ActIgnore;
        end else if (dg || byte_i == ChMinus || byte_i == ChPlus) begin
          next_o = StInt;
          act_o  = ActCopy;
        end else if (byte_i == ChDot) begin
          next_o = StFloat;
          act_o  = ActCopy;
        end else if (byte_i == ChSlash) begin
          next_o = StRef;
          act_o  = ActIgnore;
        end else if (al || spc) begin
          next_o = StToken;
          act_o  = ActCopy;
        end else if (byte_i == ChLParen) begin
          next_o = StString;
          act_o  = ActIgnore;
        end else if (sp) begin
          act_o = ActOutput;
        end else if (byte_i == ChLBrace) begin
          next_o = StBlkOpen;
          act_o  = ActCopy;
        end else if (byte_i == ChRBrace) begin
          next_o = StBlkClos;
          act_o  = ActCopy;
        end else if (byte_i == ChLBrack) begin
          next_o = StArrOpen;
          act_o  = ActCopy;
        end else if (byte_i == ChRBrack) begin
          next_o = StArrClos;
          act_o  = ActCopy;
        end
      end
    endcase
  end

endmodule

// ===== hw/rtl/tlex_res_fifo.sv =====
module tlex_res_fifo
  import tlex_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_n_i,
  input  res_t       push0_i,
  input  res_t       push1_i,
  input  logic       pop_i,
  output logic       valid_o,
  output res_t       head_o,
  output logic       room_o
);

  localparam int unsigned AW   = $clog2(ResDepth);
  localparam int unsigned CntW = AW + 1;

  res_t            mem_q [ResDepth];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_after_pop;
  logic            pop;

  assign valid_o       = (cnt_q != '0);
  assign pop           = pop_i && valid_o;
  assign head_o        = mem_q[rd_q];
  assign wr_nx         = wr_q + AW'(1);
  assign cnt_after_pop = cnt_q - CntW'(pop);
  assign room_o        = (cnt_after_pop <= CntW'(ResDepth - 2));

  assign wr_d  = wr_q + AW'(push_n_i);
  assign rd_d  = rd_q + AW'(pop);
  assign cnt_d = cnt_after_pop + CntW'(push_n_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_nx] <= push1_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ResDepth))
    else $error("result queue count out of range");

endmodule

// ===== hw/rtl/illustrator_token_lexer_unit.sv =====
// An accepted byte is registered, then decoded and written into the result
// queue, whose head drives the output. Throughput: one byte per cycle while the
// queue has room; each result is one output beat, and an unget byte can yield two.
// Decode is one combinational pass of the transition logic per byte.
// Reset (async, active low) returns the lexer to start, clears halt and empties
// the result queue.
module illustrator_token_lexer_unit
  import tlex_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       restart_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] event_kind_o,
  output logic [7:0] data_byte_o,
  output logic       last_of_run_o
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       restart_q;
  lex_state_e state_q, state_d, cur_state, next1, next2;
  lex_act_e   act1, act2;
  logic       halted_q, halted_d, halted_eff;
  logic       room, consume, pop;
  logic       va, vb;
  res_t       ra, rb, d0, d1, head;
  logic [1:0] n, push_n;
  ev_kind_e   kind1;

  assign consume    = in_valid_q && room;
  assign in_ready_o = !in_valid_q || consume;
  assign in_valid_d = (in_valid_i && in_ready_o) || (in_valid_q && !consume);

  assign cur_state  = restart_q ? StStart : state_q;
  assign halted_eff = halted_q && !restart_q;
  assign kind1      = ev_kind_e'(4'(cur_state));

  tlex_decode u_dec1 (
    .state_i (cur_state),
    .byte_i  (byte_q),
    .next_o  (next1),
    .act_o   (act1)
  );

  tlex_decode u_dec2 (
    .state_i (StStart),
    .byte_i  (byte_q),
    .next_o  (next2),
    .act_o   (act2)
  );

  always_comb begin
    va = 1'b0;
    ra = '{kind: EvChar, data: 8'h00, last: 1'b0};
    case (act1)
      ActCopy: begin
        va = 1'b1;
        ra = '{kind: EvChar, data: byte_q, last: 1'b0};
      end
      ActOutput, ActUnget: begin
        va = (cur_state != StStart);
        ra = '{kind: kind1, data: 8'h00, last: 1'b0};
      end
      ActAbort: begin
        va = 1'b1;
        ra = '{kind: EvAbort, data: 8'h00, last: 1'b0};
      end
      default: va = 1'b0;
    endcase

    vb = 1'b0;
    rb = '{kind: EvChar, data: 8'h00, last: 1'b0};
    if (act1 == ActUnget) begin
      case (act2)
        ActCopy: begin
          vb = 1'b1;
          rb = '{kind: EvChar, data: byte_q, last: 1'b0};
        end
        ActAbort: begin
          vb = 1'b1;
          rb = '{kind: EvAbort, data: 8'h00, last: 1'b0};
        end
        default: vb = 1'b0;
      endcase
    end
  end

  always_comb begin
    d0 = ra;
    d1 = rb;
    n  = 2'd0;
    if (va && vb) begin
      n = 2'd2;
    end else if (va) begin
      n = 2'd1;
    end else if (vb) begin
      d0 = rb;
      n  = 2'd1;
    end
    d0.last = (n == 2'd1);
    d1.last = 1'b1;
    if (halted_eff) begin
      n = 2'd0;
    end
  end

  assign push_n = consume ? n : 2'd0;

  always_comb begin
    state_d  = state_q;
    halted_d = halted_q;
    if (consume) begin
      if (halted_eff) begin
        state_d = cur_state;
      end else if (act1 == ActAbort || (act1 == ActUnget && act2 == ActAbort)) begin
        state_d  = StStart;
        halted_d = 1'b1;
      end else if (act1 == ActUnget) begin
        state_d  = next2;
        halted_d = 1'b0;
      end else begin
        state_d  = next1;
        halted_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= StStart;
      halted_q   <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      state_q    <= state_d;
      halted_q   <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q    <= in_byte_i;
      restart_q <= restart_i;
    end
  end

  assign pop = out_valid_o && out_ready_i;

  tlex_res_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (d0),
    .push1_i  (d1),
    .pop_i    (pop),
    .valid_o  (out_valid_o),
    .head_o   (head),
    .room_o   (room)
  );

  assign event_kind_o  = 4'(head.kind);
  assign data_byte_o   = head.data;
  assign last_of_run_o = head.last;

  a_halt_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> state_q == StStart)
    else $error("halted with lexer away from start");

  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !room |=> in_valid_q && $stable(byte_q))
    else $error("pending byte lost while queue full");

  a_two_unget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n == 2'd2 |-> act1 == ActUnget && !halted_eff)
    else $error("double result without unget");

endmodule
